// ===== sv/csgl_pkg.sv =====
// csgl_pkg: shared types and constants for the segment glyph lookup block.
// No dependencies; included first by every other file except csgl_out_if.
package csgl_pkg;

  localparam int SEGMENTS = 64;             // cells in the chain, one entry each
  localparam int CNT_W    = 7;              // segment_count register width
  localparam int IDX_W    = 6;              // entry_index field width
  localparam int ADDR_W   = 3;              // APB byte address, two 32-bit registers

  localparam logic [31:0] NO_GLYPH = 32'hFFFF_FFFF;

  // request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // status codes
  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_BAD_VS = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  // lookup token travelling down the chain
  typedef struct packed {
    logic        valid;
    logic        bad;     // unsupported selector, passes untouched
    logic        hit;     // matched in an earlier cell
    logic [31:0] cp;
    logic [31:0] glyph;
  } token_t;

  // entry data broadcast to all cells on a write
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] stop;
    logic [31:0] value;
    logic        flag;
  } seg_wr_t;

  // per-cell control
  typedef struct packed {
    logic wr_en;    // this cell is the write target
    logic active;   // cell index below segment_count
    logic fmt12;    // format 12 mode
    logic adv;      // chain advances this cycle
  } cell_ctrl_t;

endpackage

// ===== sv/csgl_in_if.sv =====
// csgl_in_if: valid/ready channel carrying one request item.
// Depends on csgl_pkg (field widths).
interface csgl_in_if;
  import csgl_pkg::*;

  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] entry_index;
  logic [31:0]      seg_start;
  logic [31:0]      seg_end;
  logic [31:0]      seg_value;
  logic             seg_range_flag;
  logic [31:0]      code_point;
  logic [31:0]      variation_selector;

  modport source (output valid, req_type, entry_index, seg_start, seg_end, seg_value,
                  seg_range_flag, code_point, variation_selector, input ready);
  modport sink   (input valid, req_type, entry_index, seg_start, seg_end, seg_value,
                  seg_range_flag, code_point, variation_selector, output ready);
endinterface

// ===== sv/csgl_out_if.sv =====
// csgl_out_if: valid/ready channel carrying one lookup result item.
// No package dependency.
interface csgl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] glyph_id;
  logic [1:0]  status;

  modport source (output valid, glyph_id, status, input ready);
  modport sink   (input valid, glyph_id, status, output ready);
endinterface

// ===== sv/csgl_cell.sv =====
// csgl_cell: one segment entry plus one token stage of the lookup chain.
// Depends on csgl_pkg.
module csgl_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csgl_pkg::cell_ctrl_t ctrl,
  input  csgl_pkg::seg_wr_t    wr,
  input  csgl_pkg::token_t     tok_in,
  output csgl_pkg::token_t     tok_r
);
  import csgl_pkg::*;

  logic [31:0] start_r;
  logic [31:0] end_r;
  logic [31:0] off_r;    // value - start, format 12 offset
  logic [15:0] dlt_r;    // format 4 delta
  logic        flag_r;
  logic        match;
  token_t      tok_nxt;

  // entry storage, undefined until written
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      start_r <= wr.start;
      end_r   <= wr.stop;
      off_r   <= wr.value - wr.start;
      dlt_r   <= wr.value[15:0];
      flag_r  <= wr.flag;
    end
  end

  always_comb begin
    match = tok_in.valid && !tok_in.bad && !tok_in.hit && ctrl.active &&
            (tok_in.cp >= start_r) && (tok_in.cp <= end_r) &&
            (ctrl.fmt12 || !flag_r);
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit = 1'b1;
      if (ctrl.fmt12) begin
        tok_nxt.glyph = tok_in.cp + off_r;
      end else begin
        tok_nxt.glyph = {16'h0000, tok_in.cp[15:0] + dlt_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (ctrl.adv) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

// ===== sv/cmap_segment_glyph_lookup_top.sv =====
// cmap_segment_glyph_lookup_top: segment table glyph lookup, chain of entry cells.
// Depends on csgl_pkg, csgl_in_if, csgl_out_if and csgl_cell.
//
// Usage notes:
//  - in_ch carries items. A write item (req_type 0) loads segment entry_index
//    into its cell in the accepting cycle and produces no result.
//  - A lookup item (req_type 1) enters the chain as a token and moves one cell
//    per cycle unless the chain is held; the first enabled cell whose range holds
//    the code point fixes the glyph, but format 4 passes over flagged cells.
//    Cells at or beyond segment_count are bypassed. The token passes every cell
//    register and then the output register before its result appears on out_ch.
//    A nonzero variation selector passes the chain untouched the same way.
//  - One lookup is in the chain at a time: in_ch.ready drops while a token is
//    travelling and rises again as its result enters the output register. A new
//    lookup waits for that; writes run one per cycle while no lookup is in flight.
//  - The output register holds a result while out_ch is stalled; the next
//    item is still taken. A second result reaching the chain end then holds
//    the chain (and in_ch.ready) until the first one is taken.
//  - cfg_*: APB registers, format_mode at 0x0 (reset 1), segment_count at 0x4
//    (reset 0). Write them only while the block is idle.
//  - Synchronous active-low reset clears control and chain state and resets the
//    cfg registers; entry storage and output glyph/status start undefined.
module cmap_segment_glyph_lookup_top (
  input  logic                        clk,
  input  logic                        rst_n,
  csgl_in_if.sink                     in_ch,
  csgl_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [csgl_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import csgl_pkg::*;

  // configuration registers
  logic             fmt_r;
  logic [CNT_W-1:0] cnt_r;
  logic             cfg_wr;

  // control
  logic busy_r;
  logic in_acc;
  logic lk_acc;
  logic wr_acc;
  logic adv;
  logic out_load;

  // output register
  logic        out_valid_r;
  logic [31:0] out_glyph_r;
  logic [1:0]  out_status_r;

  // chain
  token_t                inj;
  seg_wr_t               wr_data;
  token_t                tok_q  [SEGMENTS];
  token_t                tok_in [SEGMENTS];
  cell_ctrl_t            ctrl   [SEGMENTS];
  logic   [SEGMENTS-1:0] tok_valid;
  token_t                tail;

  // ---------------- APB configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b1;
      cnt_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_FORMAT: fmt_r <= cfg_pwdata[0];
        REG_COUNT:  cnt_r <= cfg_pwdata[CNT_W-1:0];
        default:    fmt_r <= fmt_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_FORMAT: cfg_prdata = {31'h0, fmt_r};
      REG_COUNT:  cfg_prdata = {{(32-CNT_W){1'b0}}, cnt_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------- input side ----------------
  // one lookup in flight; writes only while the chain is empty
  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign lk_acc      = in_acc && (in_ch.req_type == REQ_LOOKUP);
  assign wr_acc      = in_acc && (in_ch.req_type == REQ_WRITE);

  always_comb begin
    inj.valid = lk_acc;
    inj.bad   = (in_ch.variation_selector != 32'h0);
    inj.hit   = 1'b0;
    inj.cp    = in_ch.code_point;
    inj.glyph = NO_GLYPH;
  end

  assign wr_data.start = in_ch.seg_start;
  assign wr_data.stop  = in_ch.seg_end;
  assign wr_data.value = in_ch.seg_value;
  assign wr_data.flag  = in_ch.seg_range_flag;

  // ---------------- cell chain ----------------
  // the chain only stops when a finished token cannot leave
  assign tail     = tok_q[SEGMENTS-1];
  assign out_load = tail.valid && (!out_valid_r || out_ch.ready);
  assign adv      = !(tail.valid && !out_load);

  for (genvar i = 0; i < SEGMENTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = inj;
    end else begin : g_link
      assign tok_in[i] = tok_q[i-1];
    end

    assign ctrl[i].wr_en  = wr_acc && (32'(in_ch.entry_index) == i);
    assign ctrl[i].active = (32'(cnt_r) > i);
    assign ctrl[i].fmt12  = fmt_r;
    assign ctrl[i].adv    = adv;
    assign tok_valid[i]   = tok_q[i].valid;

    csgl_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl[i]),
      .wr     (wr_data),
      .tok_in (tok_in[i]),
      .tok_r  (tok_q[i])
    );
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (lk_acc) begin
        busy_r <= 1'b1;
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (tail.bad) begin
        out_glyph_r  <= NO_GLYPH;
        out_status_r <= ST_BAD_VS;
      end else if (tail.hit) begin
        out_glyph_r  <= tail.glyph;
        out_status_r <= ST_FOUND;
      end else begin
        out_glyph_r  <= NO_GLYPH;
        out_status_r <= ST_MISS;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.glyph_id = out_glyph_r;
  assign out_ch.status   = out_status_r;

  // ---------------- assertions ----------------
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valid) <= 1)
    else $error("more than one lookup token in the chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (tok_valid == '0))
    else $error("token in chain while not busy");

  a_inject: assert property (@(posedge clk) disable iff (!rst_n)
    lk_acc |=> tok_valid[0])
    else $error("accepted lookup did not enter the chain");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tail.valid))
    else $error("result appeared without a token at the chain end");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for cmap_segment_glyph_lookup_top (segment table glyph lookup).
// Depends on csgl_pkg, csgl_in_if, csgl_out_if and the block itself; no files or arguments.
module tb;
  import csgl_pkg::*;

  // Byte addresses of the two registers on the APB port
  localparam logic [ADDR_W-1:0] ADDR_FORMAT = {REG_FORMAT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_COUNT  = {REG_COUNT, 2'b00};

  // Cycles with no handshake anywhere before the run is declared hung. Slowest
  // honest gap is the long output hold (LONG_HOLD) plus one chain pass and a
  // settle pause; this is several times that.
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 3000;
  // Chain length plus margin; used for the idle pause before a register write
  localparam int DRAIN_WAIT  = SEGMENTS + 8;

  // One request item as offered on in_ch
  typedef struct {
    logic             req;
    logic [IDX_W-1:0] idx;
    logic [31:0]      seg_start;
    logic [31:0]      seg_end;
    logic [31:0]      seg_value;
    logic             seg_flag;
    logic [31:0]      code;
    logic [31:0]      vsel;
  } seg_req_t;

  // One lookup result
  typedef struct packed {
    logic [31:0] glyph;
    logic [1:0]  status;
  } glyph_res_t;

  logic clk;
  logic rst_n;

  csgl_in_if  in_ch ();
  csgl_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  cmap_segment_glyph_lookup_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: segment store, registers and which entries hold data
  // ---------------------------------------------------------------------------
  logic [31:0]      tbl_start [SEGMENTS];
  logic [31:0]      tbl_end   [SEGMENTS];
  logic [31:0]      tbl_value [SEGMENTS];
  logic             tbl_flag  [SEGMENTS];
  bit               tbl_loaded[SEGMENTS];
  logic             cfg_fmt12;
  logic [CNT_W-1:0] cfg_count;

  glyph_res_t glyph_expect_q[$];   // lookups accepted, result not yet seen
  int         err_count;
  bit         idle_on;             // random bubbles on both channels
  int         hold_requests;       // bumped to ask the sink for one long hold

  // Clock: 8 ns period
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: the glyph a lookup should give against the shadow store
  // ---------------------------------------------------------------------------
  function automatic glyph_res_t map_code(input logic [31:0] cp, input logic [31:0] vs);
    glyph_res_t r;
    int lim;
    r.glyph  = NO_GLYPH;
    r.status = ST_MISS;
    if (vs != 32'd0) begin
      // unsupported selector: no scan at all
      r.status = ST_BAD_VS;
      return r;
    end
    // count above the table size searches the whole table
    lim = (cfg_count > SEGMENTS) ? SEGMENTS : int'(cfg_count);
    for (int i = 0; i < lim; i++) begin
      if (cp < tbl_start[i] || cp > tbl_end[i]) continue;
      if (cfg_fmt12) begin
        // sequential group; range flag ignored, 0xFFFFFFFF may be a real hit
        r.glyph  = tbl_value[i] + (cp - tbl_start[i]);
        r.status = ST_FOUND;
        return r;
      end
      // format 4: range-offset segments are passed over
      if (tbl_flag[i]) continue;
      r.glyph  = {16'h0000, cp[15:0] + tbl_value[i][15:0]};
      r.status = ST_FOUND;
      return r;
    end
    return r;
  endfunction

  // Apply an accepted item to the shadow store or queue its expected result
  task automatic absorb_item(input seg_req_t it);
    if (it.req == REQ_WRITE) begin
      tbl_start[it.idx]  = it.seg_start;
      tbl_end[it.idx]    = it.seg_end;
      tbl_value[it.idx]  = it.seg_value;
      tbl_flag[it.idx]   = it.seg_flag;
      tbl_loaded[it.idx] = 1'b1;
    end else begin
      glyph_expect_q.push_back(map_code(it.code, it.vsel));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic seg_req_t write_req(input int idx, input logic [31:0] s,
                                         input logic [31:0] e, input logic [31:0] v,
                                         input logic f);
    seg_req_t it;
    it.req       = REQ_WRITE;
    it.idx       = idx[IDX_W-1:0];
    it.seg_start = s;
    it.seg_end   = e;
    it.seg_value = v;
    it.seg_flag  = f;
    it.code      = $urandom();    // don't-care on a write
    it.vsel      = $urandom();
    return it;
  endfunction

  function automatic seg_req_t lookup_req(input logic [31:0] cp, input logic [31:0] vs);
    seg_req_t it;
    it.req       = REQ_LOOKUP;
    it.idx       = IDX_W'($urandom_range(0, SEGMENTS - 1));   // don't-care on a lookup
    it.seg_start = $urandom();
    it.seg_end   = $urandom();
    it.seg_value = $urandom();
    it.seg_flag  = 1'($urandom_range(0, 1));
    it.code      = cp;
    it.vsel      = vs;
    return it;
  endfunction

  // Random segment: mostly narrow ranges so later entries stay reachable,
  // some empty (end below start) and the odd full-range one
  function automatic seg_req_t random_write(input int idx);
    logic [31:0] s;
    logic [31:0] e;
    int unsigned r;
    r = $urandom_range(0, 99);
    s = (r < 40) ? 32'($urandom_range(0, 16'hFFFF)) : $urandom();
    if (r < 3) begin
      s = 32'h0;
      e = NO_GLYPH;
    end else if (r < 10) begin
      e = s - 32'($urandom_range(1, 50));
    end else if (r < 15) begin
      e = s;
    end else begin
      e = s + 32'($urandom_range(0, 400));
    end
    return write_req(idx, s, e, $urandom(), ($urandom_range(0, 2) == 0));
  endfunction

  // Code point for a random lookup: mostly inside a searched segment
  function automatic logic [31:0] pick_code();
    int unsigned r;
    int          lim;
    int          j;
    logic [63:0] span;
    logic [63:0] off;
    r   = $urandom_range(0, 99);
    lim = (cfg_count > SEGMENTS) ? SEGMENTS : int'(cfg_count);
    if (r < 4) return 32'h0;
    if (r < 8) return NO_GLYPH;
    if (r < 75 && lim > 0) begin
      j = $urandom_range(0, lim - 1);
      if (tbl_start[j] <= tbl_end[j]) begin
        if (r < 20) return tbl_start[j];
        if (r < 30) return tbl_end[j];
        span = {32'h0, tbl_end[j]} - {32'h0, tbl_start[j]} + 64'd1;
        off  = {$urandom(), $urandom()} % span;
        return tbl_start[j] + off[31:0];
      end
    end
    return $urandom();
  endfunction

  function automatic seg_req_t random_lookup();
    logic [31:0] vs;
    vs = 32'h0;
    if ($urandom_range(0, 9) == 0) vs = $urandom() | (32'h1 << $urandom_range(0, 31));
    return lookup_req(pick_code(), vs);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------
  // Offer one item and hold it until accepted. valid is left high on return so
  // back-to-back items never lower and raise it in the same step.
  task automatic send_item(input seg_req_t it);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid              <= 1'b1;
    in_ch.req_type           <= it.req;
    in_ch.entry_index        <= it.idx;
    in_ch.seg_start          <= it.seg_start;
    in_ch.seg_end            <= it.seg_end;
    in_ch.seg_value          <= it.seg_value;
    in_ch.seg_range_flag     <= it.seg_flag;
    in_ch.code_point         <= it.code;
    in_ch.variation_selector <= it.vsel;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    absorb_item(it);
  endtask

  // Drop valid, wait for every result, then let the chain run empty
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (glyph_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // APB write: setup cycle then access cycle; pready is always high
  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Load any entry the new count would search but that holds nothing yet
  task automatic fill_entries(input int cnt);
    int lim;
    lim = (cnt > SEGMENTS) ? SEGMENTS : cnt;
    for (int i = 0; i < lim; i++)
      if (!tbl_loaded[i]) send_item(random_write(i));
  endtask

  // New setting: entries first, then both registers once the block is idle
  task automatic configure(input bit fmt12, input int cnt);
    fill_entries(cnt);
    settle();
    apb_write(ADDR_FORMAT, {31'h0, fmt12});
    apb_write(ADDR_COUNT, 32'(cnt));
    cfg_fmt12 = fmt12;
    cfg_count = cnt[CNT_W-1:0];
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    if (err_count < 50)
      $display("tb: mismatch on %s: expected %h, got %h", what, exp_v, got_v);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    glyph_res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (glyph_expect_q.size() == 0) begin
        report_mismatch("unexpected result glyph", 32'h0, out_ch.glyph_id);
      end else begin
        want = glyph_expect_q.pop_front();
        if (out_ch.glyph_id !== want.glyph)
          report_mismatch("glyph_id", want.glyph, out_ch.glyph_id);
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_ch.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random bubbles, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int hold_seen;
    int stall_left;
    hold_seen  = 0;
    stall_left = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen  = hold_requests;
        stall_left = LONG_HOLD;
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 8);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long with no handshake on any port means a hang
  always @(posedge clk) begin
    int quiet;
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_psel && cfg_penable)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values: format 12, count 0: lookups miss without a scan, bad selector reported
  task automatic test_reset_state();
    send_item(lookup_req(32'h0000_0041, 32'h0));
    send_item(lookup_req(NO_GLYPH, 32'h0));
    send_item(lookup_req(32'h0000_0041, 32'h0000_0001));
  endtask

  // Format 12: range edges, priority of the first match, flag ignored,
  // found glyph of all ones, both selector extremes
  task automatic test_format12();
    send_item(write_req(0, 32'h0000_0041, 32'h0000_005A, 32'd100, 1'b0));
    send_item(write_req(1, 32'h0000_0050, 32'h0000_0060, 32'h1234_FFF0, 1'b0));
    send_item(write_req(2, 32'hFFFF_FF00, NO_GLYPH, 32'hFFFF_FF00, 1'b0));
    send_item(write_req(3, 32'h0000_1000, 32'h0000_10FF, 32'h0000_8000, 1'b1));
    configure(1'b1, 4);
    send_item(lookup_req(32'h0000_0041, 32'h0));   // start edge
    send_item(lookup_req(32'h0000_005A, 32'h0));   // end edge
    send_item(lookup_req(32'h0000_0055, 32'h0));   // overlap, first entry wins
    send_item(lookup_req(32'h0000_005B, 32'h0));   // second entry
    send_item(lookup_req(32'h0000_0040, 32'h0));   // just below: miss
    send_item(lookup_req(NO_GLYPH, 32'h0));        // hit giving all ones
    send_item(lookup_req(32'h0000_1080, 32'h0));   // flagged entry still used
    send_item(lookup_req(32'h0000_0041, NO_GLYPH));
  endtask

  // Format 4: positive and negative deltas, 16-bit wrap, flagged entries skipped
  task automatic test_format4();
    send_item(write_req(4, 32'h0000_1000, 32'h0000_1FFF, 32'hABCD_8000, 1'b0));
    configure(1'b0, 5);
    send_item(lookup_req(32'h0000_0045, 32'h0));   // delta +100
    send_item(lookup_req(32'h0000_005B, 32'h0));   // delta -16
    send_item(lookup_req(NO_GLYPH, 32'h0));        // wraps modulo 65536
    send_item(lookup_req(32'h0000_1050, 32'h0));   // flagged skipped, next entry
    send_item(lookup_req(32'h0000_2000, 32'h0));   // miss
    send_item(lookup_req(32'h0000_1050, 32'h8000_0000));
  endtask

  // Random traffic over several settings, the count extremes among them
  task automatic test_random_mix();
    bit fmt_set[7] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    int cnt_set[7] = '{64, 127, 17, 64, 1, 0, 127};
    idle_on = 1'b1;
    foreach (cnt_set[p]) begin
      configure(fmt_set[p], cnt_set[p]);
      repeat (85) begin
        if ($urandom_range(0, 3) == 0)
          send_item(random_write($urandom_range(0, SEGMENTS - 1)));
        else
          send_item(random_lookup());
      end
    end
  endtask

  // Receiver holds off for a long stretch while lookups keep coming, so the
  // output register fills, a second result holds the chain and in_ch stalls
  task automatic test_backpressure();
    configure(1'b1, 64);
    idle_on = 1'b0;
    @(negedge clk);
    hold_requests++;
    repeat (10) send_item(random_lookup());
  endtask

  // Closing stretch with both sides running flat out
  task automatic test_full_rate();
    configure(1'b0, 64);
    idle_on = 1'b0;
    repeat (60) begin
      if ($urandom_range(0, 2) == 0)
        send_item(random_write($urandom_range(0, SEGMENTS - 1)));
      else
        send_item(random_lookup());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.req_type           = REQ_WRITE;
    in_ch.entry_index        = '0;
    in_ch.seg_start          = '0;
    in_ch.seg_end            = '0;
    in_ch.seg_value          = '0;
    in_ch.seg_range_flag     = 1'b0;
    in_ch.code_point         = '0;
    in_ch.variation_selector = '0;
    cfg_psel                 = 1'b0;
    cfg_penable              = 1'b0;
    cfg_pwrite               = 1'b0;
    cfg_paddr                = '0;
    cfg_pwdata               = '0;
    err_count                = 0;
    idle_on                  = 1'b0;
    hold_requests            = 0;
    cfg_fmt12                = 1'b1;
    cfg_count                = '0;
    foreach (tbl_loaded[i]) tbl_loaded[i] = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_format12();
    test_format4();
    test_random_mix();
    test_backpressure();
    test_full_rate();

    settle();
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
